/* sv/cfes_pkg.sv */
// Package for the epoch-seconds to calendar converter: constants, widths,
// leap-year and month-length helpers. No dependencies.
package cfes_pkg;

   localparam int unsigned EpochW    = 32;  // input seconds count
   localparam int unsigned DaysW     = 16;  // whole days since the epoch, < 49711
   localparam int unsigned CntW      = 4;   // restoring-division step counter
   localparam int unsigned YearW     = 8;   // year minus 1900
   localparam int unsigned YdayW     = 9;
   localparam int unsigned MonthW    = 4;
   localparam int unsigned DomW      = 5;

   localparam logic [EpochW-1:0] SecPerDay  = 32'd86400;
   localparam logic [EpochW-1:0] SecPerHour = 32'd3600;
   localparam logic [EpochW-1:0] SecPerMin  = 32'd60;
   localparam logic [EpochW-1:0] DaysPerWk  = 32'd7;
   localparam logic [EpochW-1:0] CommonYear = 32'd365;
   localparam logic [EpochW-1:0] QuadYears  = 32'd1460;  // four common years

   // Top quotient bit index of each restoring division
   localparam logic [CntW-1:0] DayTopBit  = 4'd15;  // days < 2^16
   localparam logic [CntW-1:0] HourTopBit = 4'd4;   // hour < 2^5
   localparam logic [CntW-1:0] MinTopBit  = 4'd5;   // minute < 2^6
   localparam logic [CntW-1:0] WdayTopBit = 4'd12;  // (days + 4) / 7 < 2^13

   localparam logic [EpochW-1:0] WeekdayOfs = 32'd4;   // 1970-01-01 was a Thursday
   localparam logic [YearW-1:0]  FirstYear  = 8'd70;   // 1970
   localparam logic [YearW-1:0]  Year2100   = 8'd200;  // only non-leap century in range

   localparam logic [MonthW-1:0] MonJan = 4'd0;
   localparam logic [MonthW-1:0] MonFeb = 4'd1;

   // Valid for 1901..2155: divisible by 4 except 2100.
   function automatic logic leap_year(input logic [YearW-1:0] ys);
      return (ys[1:0] == 2'b00) && (ys != Year2100);
   endfunction

   function automatic logic [DomW-1:0] month_days(input logic [MonthW-1:0] m,
                                                  input logic leap);
      logic [DomW-1:0] len;
      case (m)
         4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: len = 5'd31;
         4'd3, 4'd5, 4'd8, 4'd10:                   len = 5'd30;
         MonFeb:                                    len = leap ? 5'd29 : 5'd28;
         default:                                   len = 5'd31;
      endcase
      return len;
   endfunction

endpackage

/* sv/calendar_from_epoch_seconds_core.sv */
// Channel  Dir  Handshake          Payload
// req      in   req_valid/ready    req_epoch_seconds (32b unsigned)
// rsp      out  rsp_valid/ready    second, minute, hour, years_since_1900,
//                                  day_of_year, weekday, month, day_of_month
//
// A conversion divides out days, hours, minutes and weekday, then walks
// four-year blocks, single years and months, one step per cycle on the
// single compare-and-subtract unit, except while the month step holds.
// req_ready is high only while the sequencer is idle; a finished result
// waits in the output register, and the next conversion may run meanwhile.
// If that result is still waiting when the next one is done, hold in the
// month step until rsp_ready frees the register.
// Synchronous active-high reset clears the sequencer and rsp_valid.
// Top level of the epoch-seconds to calendar converter.
// Depends on cfes_pkg and cfes_sub.
module calendar_from_epoch_seconds_core (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [cfes_pkg::EpochW-1:0]  req_epoch_seconds,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [5:0]                   rsp_second,
   output logic [5:0]                   rsp_minute,
   output logic [4:0]                   rsp_hour,
   output logic [cfes_pkg::YearW-1:0]   rsp_years_since_1900,
   output logic [cfes_pkg::YdayW-1:0]   rsp_day_of_year,
   output logic [2:0]                   rsp_weekday,
   output logic [cfes_pkg::MonthW-1:0]  rsp_month,
   output logic [cfes_pkg::DomW-1:0]    rsp_day_of_month
);
   import cfes_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_DAY, S_HOUR, S_MIN, S_WDAY, S_YBLK, S_YEAR, S_MON
   } state_type;

   state_type         state_ff, state_in;
   logic [EpochW-1:0] acc_ff, acc_in;
   logic [DaysW-1:0]  quo_ff, quo_in;
   logic [DaysW-1:0]  days_ff, days_in;
   logic [CntW-1:0]   cnt_ff, cnt_in;
   logic [4:0]        hour_ff, hour_in;
   logic [5:0]        minute_ff, minute_in;
   logic [5:0]        second_ff, second_in;
   logic [2:0]        weekday_ff, weekday_in;
   logic [YearW-1:0]  ys_ff, ys_in;
   logic [YdayW-1:0]  yday_ff, yday_in;
   logic [MonthW-1:0] month_ff, month_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [5:0]        rsp_second_ff, rsp_second_in;
   logic [5:0]        rsp_minute_ff, rsp_minute_in;
   logic [4:0]        rsp_hour_ff, rsp_hour_in;
   logic [YearW-1:0]  rsp_year_ff, rsp_year_in;
   logic [YdayW-1:0]  rsp_yday_ff, rsp_yday_in;
   logic [2:0]        rsp_wday_ff, rsp_wday_in;
   logic [MonthW-1:0] rsp_month_ff, rsp_month_in;
   logic [DomW-1:0]   rsp_dom_ff, rsp_dom_in;

   logic [EpochW-1:0] sub_b;
   logic [EpochW-1:0] sub_diff;
   logic              sub_ge;
   logic [EpochW-1:0] rem_next;
   logic [DaysW-1:0]  quo_shift;
   logic [YearW-1:0]  ys_plus2;

   cfes_sub u_sub (
      .a    (acc_ff),
      .b    (sub_b),
      .diff (sub_diff),
      .ge   (sub_ge)
   );

   assign rem_next  = sub_ge ? sub_diff : acc_ff;
   assign quo_shift = {quo_ff[DaysW-2:0], sub_ge};
   assign ys_plus2  = ys_ff + 8'd2;

   // Divisor or subtrahend for the current step
   always_comb begin
      case (state_ff)
         S_DAY:   sub_b = SecPerDay << cnt_ff;
         S_HOUR:  sub_b = SecPerHour << cnt_ff;
         S_MIN:   sub_b = SecPerMin << cnt_ff;
         S_WDAY:  sub_b = DaysPerWk << cnt_ff;
         S_YBLK:  sub_b = QuadYears + EpochW'(leap_year(ys_plus2));
         S_YEAR:  sub_b = CommonYear + EpochW'(leap_year(ys_ff));
         S_MON:   sub_b = EpochW'(month_days(month_ff, leap_year(ys_ff)));
         default: sub_b = '0;
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      acc_in        = acc_ff;
      quo_in        = quo_ff;
      days_in       = days_ff;
      cnt_in        = cnt_ff;
      hour_in       = hour_ff;
      minute_in     = minute_ff;
      second_in     = second_ff;
      weekday_in    = weekday_ff;
      ys_in         = ys_ff;
      yday_in       = yday_ff;
      month_in      = month_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_second_in = rsp_second_ff;
      rsp_minute_in = rsp_minute_ff;
      rsp_hour_in   = rsp_hour_ff;
      rsp_year_in   = rsp_year_ff;
      rsp_yday_in   = rsp_yday_ff;
      rsp_wday_in   = rsp_wday_ff;
      rsp_month_in  = rsp_month_ff;
      rsp_dom_in    = rsp_dom_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               acc_in   = req_epoch_seconds;
               quo_in   = '0;
               cnt_in   = DayTopBit;
               state_in = S_DAY;
            end
         end
         S_DAY: begin
            acc_in = rem_next;
            quo_in = quo_shift;
            cnt_in = cnt_ff - 4'd1;
            if (cnt_ff == '0) begin
               days_in  = quo_shift;
               quo_in   = '0;
               cnt_in   = HourTopBit;
               state_in = S_HOUR;
            end
         end
         S_HOUR: begin
            acc_in = rem_next;
            quo_in = quo_shift;
            cnt_in = cnt_ff - 4'd1;
            if (cnt_ff == '0) begin
               hour_in  = quo_shift[4:0];
               quo_in   = '0;
               cnt_in   = MinTopBit;
               state_in = S_MIN;
            end
         end
         S_MIN: begin
            acc_in = rem_next;
            quo_in = quo_shift;
            cnt_in = cnt_ff - 4'd1;
            if (cnt_ff == '0) begin
               minute_in = quo_shift[5:0];
               second_in = rem_next[5:0];
               acc_in    = EpochW'(days_ff) + WeekdayOfs;
               quo_in    = '0;
               cnt_in    = WdayTopBit;
               state_in  = S_WDAY;
            end
         end
         S_WDAY: begin
            // Only the remainder matters here
            acc_in = rem_next;
            cnt_in = cnt_ff - 4'd1;
            if (cnt_ff == '0) begin
               weekday_in = rem_next[2:0];
               acc_in     = EpochW'(days_ff);
               ys_in      = FirstYear;
               state_in   = S_YBLK;
            end
         end
         S_YBLK: begin
            // Walk four-year blocks starting at years that are 2 mod 4
            if (sub_ge) begin
               acc_in = sub_diff;
               ys_in  = ys_ff + 8'd4;
            end else begin
               state_in = S_YEAR;
            end
         end
         S_YEAR: begin
            if (sub_ge) begin
               acc_in = sub_diff;
               ys_in  = ys_ff + 8'd1;
            end else begin
               yday_in  = acc_ff[YdayW-1:0];
               month_in = MonJan;
               state_in = S_MON;
            end
         end
         S_MON: begin
            if (sub_ge) begin
               acc_in   = sub_diff;
               month_in = month_ff + 4'd1;
            end else if (!rsp_valid_ff || rsp_ready) begin
               // Hold here until the output register is free
               rsp_valid_in  = 1'b1;
               rsp_second_in = second_ff;
               rsp_minute_in = minute_ff;
               rsp_hour_in   = hour_ff;
               rsp_year_in   = ys_ff;
               rsp_yday_in   = yday_ff;
               rsp_wday_in   = weekday_ff;
               rsp_month_in  = month_ff;
               rsp_dom_in    = acc_ff[DomW-1:0] + 5'd1;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      acc_ff        <= acc_in;
      quo_ff        <= quo_in;
      days_ff       <= days_in;
      cnt_ff        <= cnt_in;
      hour_ff       <= hour_in;
      minute_ff     <= minute_in;
      second_ff     <= second_in;
      weekday_ff    <= weekday_in;
      ys_ff         <= ys_in;
      yday_ff       <= yday_in;
      month_ff      <= month_in;
      rsp_second_ff <= rsp_second_in;
      rsp_minute_ff <= rsp_minute_in;
      rsp_hour_ff   <= rsp_hour_in;
      rsp_year_ff   <= rsp_year_in;
      rsp_yday_ff   <= rsp_yday_in;
      rsp_wday_ff   <= rsp_wday_in;
      rsp_month_ff  <= rsp_month_in;
      rsp_dom_ff    <= rsp_dom_in;
   end

   assign req_ready            = (state_ff == S_IDLE);
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_second           = rsp_second_ff;
   assign rsp_minute           = rsp_minute_ff;
   assign rsp_hour             = rsp_hour_ff;
   assign rsp_years_since_1900 = rsp_year_ff;
   assign rsp_day_of_year      = rsp_yday_ff;
   assign rsp_weekday          = rsp_wday_ff;
   assign rsp_month            = rsp_month_ff;
   assign rsp_day_of_month     = rsp_dom_ff;

`ifndef SYNTHESIS
   a_time_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_hour_ff < 5'd24) && (rsp_minute_ff < 6'd60)
                       && (rsp_second_ff < 6'd60) && (rsp_wday_ff < 3'd7))
      else $error("time-of-day or weekday out of range");

   a_date_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_month_ff < 4'd12) && (rsp_dom_ff != 5'd0)
                       && (rsp_yday_ff < 9'd366 || rsp_yday_ff == 9'd365))
      else $error("calendar date out of range");

   a_month_walk: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MON) |-> (month_ff < 4'd12))
      else $error("month walk ran past December");

   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_MON))
      else $error("result raised outside the month step");

   a_day_remainder: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_HOUR) |-> (acc_ff < SecPerDay))
      else $error("day remainder not below one day");
`endif

endmodule

/* sv/cfes_sub.sv */
// Shared compare-and-subtract unit of the calendar converter.
// Depends on cfes_pkg for the operand width.
module cfes_sub (
   input  logic [cfes_pkg::EpochW-1:0] a,
   input  logic [cfes_pkg::EpochW-1:0] b,
   output logic [cfes_pkg::EpochW-1:0] diff,
   output logic                        ge
);
   import cfes_pkg::*;

   logic [EpochW:0] wide_diff;

   assign wide_diff = {1'b0, a} - {1'b0, b};
   assign diff      = wide_diff[EpochW-1:0];
   assign ge        = ~wide_diff[EpochW];

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for calendar_from_epoch_seconds_core: drives epoch
// seconds, predicts each broken-down UTC time and checks every response.
// Depends on cfes_pkg and the converter RTL only.
module tb;

   localparam int unsigned SecsPerDay  = 86400;
   localparam int unsigned SecsPerHour = 3600;
   localparam int unsigned SecsPerMin  = 60;
   localparam int unsigned EpochYear   = 1970;
   localparam int unsigned RandomCount = 1580;
   localparam int unsigned SettleCycles = 120;

   typedef struct packed {
      logic [5:0] second;
      logic [5:0] minute;
      logic [4:0] hour;
      logic [7:0] years_since_1900;
      logic [8:0] day_of_year;
      logic [2:0] weekday;
      logic [3:0] month;
      logic [4:0] day_of_month;
   } calendar_type;

   typedef struct packed {
      logic [cfes_pkg::EpochW-1:0] secs;
      logic                        drain_first;  // wait for all responses first
   } conv_request_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                        req_valid = 1'b0;
   logic                        req_ready;
   logic [cfes_pkg::EpochW-1:0] req_epoch_seconds = '0;
   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   logic [5:0]                  rsp_second;
   logic [5:0]                  rsp_minute;
   logic [4:0]                  rsp_hour;
   logic [7:0]                  rsp_years_since_1900;
   logic [8:0]                  rsp_day_of_year;
   logic [2:0]                  rsp_weekday;
   logic [3:0]                  rsp_month;
   logic [4:0]                  rsp_day_of_month;

   conv_request_type pending_requests[$];
   calendar_type     expected_calendars[$];

   bit req_taken = 1'b0;
   int burst_left = 0;
   int gap_left = 0;
   int stall_left = 0;
   int ready_mode = 0;
   int mode_cycles = 0;
   int sent_count = 0;
   int checked_count = 0;
   int error_count = 0;
   int drain_count = 0;
   int directed_count = 0;

   calendar_from_epoch_seconds_core uut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_epoch_seconds    (req_epoch_seconds),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_second           (rsp_second),
      .rsp_minute           (rsp_minute),
      .rsp_hour             (rsp_hour),
      .rsp_years_since_1900 (rsp_years_since_1900),
      .rsp_day_of_year      (rsp_day_of_year),
      .rsp_weekday          (rsp_weekday),
      .rsp_month            (rsp_month),
      .rsp_day_of_month     (rsp_day_of_month)
   );

   function automatic bit is_leap(input int unsigned yr);
      return (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
   endfunction

   function automatic int unsigned month_length(input int unsigned yr, input int unsigned mo);
      int unsigned len;
      case (mo)
         3, 5, 8, 10: len = 30;
         1:           len = is_leap(yr) ? 29 : 28;
         default:     len = 31;
      endcase
      return len;
   endfunction

   // Days from the epoch to the first of the given month (month from 0).
   function automatic longint first_day_of(input int unsigned yr, input int unsigned mo);
      longint days;
      days = 0;
      for (int unsigned y = EpochYear; y < yr; y++)
         days += is_leap(y) ? 366 : 365;
      for (int unsigned m = 0; m < mo; m++)
         days += month_length(yr, m);
      return days;
   endfunction

   function automatic calendar_type to_calendar(input logic [cfes_pkg::EpochW-1:0] secs);
      calendar_type cal;
      int unsigned  days;
      int unsigned  rem;
      int unsigned  yr;
      int unsigned  mo;
      int unsigned  ylen;
      int unsigned  mlen;
      days = secs / SecsPerDay;
      rem = secs % SecsPerDay;
      cal.hour = 5'(rem / SecsPerHour);
      cal.minute = 6'((rem % SecsPerHour) / SecsPerMin);
      cal.second = 6'(rem % SecsPerMin);
      // 1970-01-01 was a Thursday
      cal.weekday = 3'((days + 4) % 7);
      yr = EpochYear;
      ylen = is_leap(yr) ? 366 : 365;
      while (days >= ylen) begin
         days -= ylen;
         yr++;
         ylen = is_leap(yr) ? 366 : 365;
      end
      cal.years_since_1900 = 8'(yr - 1900);
      cal.day_of_year = 9'(days);
      mo = 0;
      mlen = month_length(yr, mo);
      while (mo < 12 && days >= mlen) begin
         days -= mlen;
         mo++;
         mlen = month_length(yr, mo);
      end
      cal.month = 4'(mo);
      cal.day_of_month = 5'(days + 1);
      return cal;
   endfunction

   task automatic add_request(input longint secs, input bit drain);
      conv_request_type r;
      if (secs < 0)
         secs = 0;
      if (secs > longint'(32'hFFFF_FFFF))
         secs = longint'(32'hFFFF_FFFF);
      r.secs = secs[31:0];
      r.drain_first = drain;
      pending_requests.push_back(r);
   endtask

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         error_count++;
      end
   endtask

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   // Driver: bursts of transactions with random gaps; optional drain before an item
   always @(negedge clock) begin
      logic next_valid;
      conv_request_type r;
      next_valid = req_valid;
      if (!reset && !(req_valid && !req_taken)) begin
         req_taken = 1'b0;
         next_valid = 1'b0;
         if (gap_left > 0) begin
            gap_left--;
         end else if (pending_requests.size() != 0 &&
                      !(pending_requests[0].drain_first && expected_calendars.size() != 0)) begin
            r = pending_requests.pop_front();
            if (r.drain_first)
               drain_count++;
            req_epoch_seconds <= r.secs;
            next_valid = 1'b1;
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 80)
                                                        : $urandom_range(1, 8);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
            end
         end
      end
      req_valid <= next_valid;
   end

   // Receiver: stall pattern switches among always ready, random, periodic and long stalls
   always @(negedge clock) begin
      logic next_ready;
      mode_cycles++;
      if (mode_cycles >= 256) begin
         mode_cycles = 0;
         ready_mode = $urandom_range(0, 3);
      end
      case (ready_mode)
         0: next_ready = 1'b1;
         1: next_ready = 1'($urandom_range(0, 1));
         2: next_ready = (mode_cycles % 7) < 3;
         default: begin
            if (stall_left > 0) begin
               stall_left--;
               next_ready = 1'b0;
            end else begin
               next_ready = 1'b1;
               if ($urandom_range(0, 7) == 0)
                  stall_left = $urandom_range(1, 40);
            end
         end
      endcase
      rsp_ready <= next_ready;
   end

   // Monitor: predict on accepted requests, check accepted responses
   always @(posedge clock) begin
      calendar_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            expected_calendars.push_back(to_calendar(req_epoch_seconds));
            req_taken = 1'b1;
            sent_count++;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_calendars.size() == 0) begin
               $display("%0t: unexpected response, nothing outstanding", $time);
               error_count++;
            end else begin
               want = expected_calendars.pop_front();
               checked_count++;
               check_field("second", want.second, rsp_second);
               check_field("minute", want.minute, rsp_minute);
               check_field("hour", want.hour, rsp_hour);
               check_field("years_since_1900", want.years_since_1900, rsp_years_since_1900);
               check_field("day_of_year", want.day_of_year, rsp_day_of_year);
               check_field("weekday", want.weekday, rsp_weekday);
               check_field("month", want.month, rsp_month);
               check_field("day_of_month", want.day_of_month, rsp_day_of_month);
            end
         end
      end
   end

   initial begin
      longint base;
      int unsigned yr;
      int unsigned mo;
      int unsigned pick;

      // Directed: extremes, midnight and leap edges, century non-leap year
      add_request(0, 1'b0);
      add_request(32'hFFFF_FFFF, 1'b0);
      add_request(SecsPerDay - 1, 1'b0);
      add_request(SecsPerDay, 1'b0);
      add_request(946684799, 1'b0);                        // 1999-12-31 23:59:59
      add_request(946684800, 1'b0);                        // 2000-01-01
      add_request(951782399, 1'b0);                        // 2000-02-28 23:59:59
      add_request(951782400, 1'b0);                        // 2000-02-29
      add_request(951868800, 1'b0);                        // 2000-03-01
      add_request(978220800 - SecsPerDay, 1'b0);           // 2000-12-30, day 364
      add_request(32'd4102444800, 1'b0);                   // 2100-01-01
      add_request(32'd4107542399, 1'b0);                   // 2100-02-28 23:59:59
      add_request(32'd4107542400, 1'b0);                   // 2100-03-01
      add_request(first_day_of(2104, 2) * SecsPerDay - 1, 1'b0);  // 2104-02-29 end
      add_request(first_day_of(2106, 0) * SecsPerDay - 1, 1'b0);  // 2105-12-31 end
      add_request(first_day_of(2106, 0) * SecsPerDay, 1'b0);
      add_request(32'h7FFF_FFFF, 1'b0);
      add_request(32'h8000_0000, 1'b0);
      add_request(32'hAAAA_AAAA, 1'b0);
      add_request(32'h5555_5555, 1'b0);
      add_request(32'd4294944000, 1'b0);                   // first second of the last day
      add_request(32'd4294944000 - 1, 1'b0);
      directed_count = pending_requests.size();

      for (int i = 0; i < RandomCount; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            add_request($urandom, i == 0 || i == 500 || i == 1100);
         end else if (pick < 70) begin
            base = longint'($urandom_range(0, 49709)) * SecsPerDay;
            add_request(base + $urandom_range(0, SecsPerDay - 1), 1'b0);
         end else if (pick < 95) begin
            // around the first of a month or a year
            yr = $urandom_range(EpochYear, 2106);
            if (yr == 2106)
               mo = $urandom_range(0, 1);
            else
               mo = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 11);
            base = first_day_of(yr, mo) * SecsPerDay;
            add_request(base + longint'($urandom_range(0, 7)) - 4, 1'b0);
         end else begin
            add_request(longint'(32'hFFFF_FFFF) - $urandom_range(0, 40 * SecsPerDay), 1'b0);
         end
      end

      while (pending_requests.size() != 0 || req_valid || expected_calendars.size() != 0)
         @(posedge clock);
      repeat (SettleCycles) @(posedge clock);

      $display("Converted %0d epoch counts (%0d directed), %0d responses compared,",
               sent_count, directed_count, checked_count);
      $display("%0d full drains of the pipeline, %0d field errors", drain_count, error_count);
      if (error_count == 0 && expected_calendars.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   initial begin
      #4_000_000;
      $display("Timed out with %0d responses outstanding", expected_calendars.size());
      $display("FAIL");
      $finish;
   end

endmodule
